// ===== sv/dchs_pkg.sv =====
// shared constants and width helpers for the delta carriage height solver
`default_nettype none
package dchs_pkg;

  localparam int ArmWidth  = 47;
  localparam int LeanWidth = 32;
  localparam int LeanFrac  = 30;
  localparam logic signed [LeanWidth-1:0] LeanOne = 32'sd1073741824;
  localparam logic [ArmWidth-1:0] ArmReset = 47'd4096000000;

  localparam logic [2:0] RegArm   = 3'd0;
  localparam logic [2:0] RegBaseX = 3'd1;
  localparam logic [2:0] RegBaseY = 3'd2;
  localparam logic [2:0] RegLeanX = 3'd3;
  localparam logic [2:0] RegLeanY = 3'd4;
  localparam logic [2:0] RegLeanZ = 3'd5;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadArm   = 2'd1,
    StNoReach  = 2'd2,
    StBothNeg  = 2'd3
  } status_e;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // difference width, linear-term width and rounded linear width
  function automatic int dw_of(input int cw);
    return cw + 1;
  endfunction
  function automatic int linw_of(input int cw);
    return cw + 1 + LeanWidth + 2;
  endfunction
  function automatic int bw_of(input int cw);
    return linw_of(cw) - LeanFrac;
  endfunction
  function automatic int sqw_of(input int cw);
    return 2 * (cw + 1);
  endfunction
  function automatic int aw_of(input int f);
    return ArmWidth + f;
  endfunction
  function automatic int cwd_of(input int cw, input int f);
    return max2(sqw_of(cw) + 1, aw_of(f) + 1) + 2;
  endfunction
  function automatic int dsw_of(input int cw, input int f);
    return max2(2 * bw_of(cw), cwd_of(cw, f)) + 1;
  endfunction
  function automatic int nb_of(input int cw, input int f);
    return dsw_of(cw, f) / 2;
  endfunction

endpackage
`default_nettype wire

// ===== sv/dchs_front.sv =====
// products, linear term and radicand ahead of the square root chain
`default_nettype none
module dchs_front #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0]         nozzle_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]         nozzle_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]         nozzle_z_i,
  input  wire logic [dchs_pkg::ArmWidth-1:0]         arm_i,
  input  wire logic signed [COORD_WIDTH-1:0]         base_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]         base_y_i,
  input  wire logic signed [dchs_pkg::LeanWidth-1:0] lean_x_i,
  input  wire logic signed [dchs_pkg::LeanWidth-1:0] lean_y_i,
  input  wire logic signed [dchs_pkg::LeanWidth-1:0] lean_z_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [2*dchs_pkg::nb_of(COORD_WIDTH, FRAC_BITS)-1:0] rad_o,
  output logic signed [dchs_pkg::bw_of(COORD_WIDTH)-1:0]       off_o,
  output logic                                       lean_free_o,
  output logic [1:0]                                 status_o
);
  import dchs_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = dw_of(CW);
  localparam int SQW  = sqw_of(CW);
  localparam int PW   = DW + LeanWidth;
  localparam int LINW = linw_of(CW);
  localparam int BW   = bw_of(CW);
  localparam int AW   = aw_of(FRAC_BITS);
  localparam int CWD  = cwd_of(CW, FRAC_BITS);
  localparam int DSW  = dsw_of(CW, FRAC_BITS);
  localparam int RW2  = 2 * nb_of(CW, FRAC_BITS);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic r1, r2, r3, r4, r5;

  assign r5 = !v5_q || out_ready_i;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
    end
  end

  // stage 1: offsets from the tower base
  logic signed [DW-1:0] dx1_q, dy1_q;
  logic signed [CW-1:0] z1_q;
  logic                 lf1_q, az1_q;

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      dx1_q <= DW'(nozzle_x_i) - DW'(base_x_i);
      dy1_q <= DW'(nozzle_y_i) - DW'(base_y_i);
      z1_q  <= nozzle_z_i;
      lf1_q <= (lean_x_i == '0) && (lean_y_i == '0) && (lean_z_i == LeanOne);
      az1_q <= (arm_i == '0);
    end
  end

  // stage 2: all products
  logic signed [SQW-1:0]  dx2_q, dy2_q;
  logic signed [2*CW-1:0] z2_q;
  logic signed [PW-1:0]   px_q, py_q;
  logic signed [CW+LeanWidth-1:0] pz_q;
  logic signed [CW-1:0]   z2p_q;
  logic                   lf2_q, az2_q;

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      dx2_q <= dx1_q * dx1_q;
      dy2_q <= dy1_q * dy1_q;
      z2_q  <= z1_q * z1_q;
      px_q  <= dx1_q * lean_x_i;
      py_q  <= dy1_q * lean_y_i;
      pz_q  <= z1_q * lean_z_i;
      z2p_q <= z1_q;
      lf2_q <= lf1_q;
      az2_q <= az1_q;
    end
  end

  // stage 3: sums, constant term and rounded linear term
  logic signed [AW:0]     arm_sh;
  logic signed [SQW:0]    planar;
  logic signed [LINW-1:0] lin;
  logic signed [DSW-1:0]  val3_q;
  logic signed [CWD-1:0]  c3_q;
  logic signed [BW-1:0]   b3_q;
  logic signed [CW-1:0]   z3_q;
  logic                   lf3_q, az3_q;

  assign arm_sh = $signed({1'b0, arm_i, {FRAC_BITS{1'b0}}});
  assign planar = (SQW+1)'(dx2_q) + (SQW+1)'(dy2_q);
  assign lin    = LINW'(px_q) + LINW'(py_q) + LINW'(pz_q)
                + $signed(LINW'(1) <<< (LeanFrac - 1));

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      val3_q <= DSW'(arm_sh) - DSW'(planar);
      c3_q   <= CWD'(planar) + CWD'(z2_q) - CWD'(arm_sh);
      b3_q   <= BW'(lin >>> LeanFrac);
      z3_q   <= z2p_q;
      lf3_q  <= lf2_q;
      az3_q  <= az2_q;
    end
  end

  // stage 4: square of the linear term
  logic signed [2*BW-1:0] bb4_q;
  logic signed [DSW-1:0]  val4_q;
  logic signed [CWD-1:0]  c4_q;
  logic signed [BW-1:0]   b4_q;
  logic signed [CW-1:0]   z4_q;
  logic                   lf4_q, az4_q;

  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      bb4_q  <= b3_q * b3_q;
      val4_q <= val3_q;
      c4_q   <= c3_q;
      b4_q   <= b3_q;
      z4_q   <= z3_q;
      lf4_q  <= lf3_q;
      az4_q  <= az3_q;
    end
  end

  // stage 5: radicand and early status
  logic signed [DSW-1:0] rad5_q;
  logic signed [BW-1:0]  off5_q;
  logic                  lf5_q, az5_q;

  always_ff @(posedge clk_i) begin
    if (r5 && v4_q) begin
      rad5_q <= lf4_q ? val4_q : (DSW'(bb4_q) - DSW'(c4_q));
      off5_q <= lf4_q ? BW'(z4_q) : b4_q;
      lf5_q  <= lf4_q;
      az5_q  <= az4_q;
    end
  end

  always_comb begin
    status_o = StOk;
    if (az5_q) status_o = StBadArm;
    else if (rad5_q[DSW-1]) status_o = StNoReach;
    rad_o = (status_o == StOk) ? RW2'(rad5_q[DSW-2:0]) : '0;
  end

  assign off_o       = off5_q;
  assign lean_free_o = lf5_q;
  assign out_valid_o = v5_q;

endmodule
`default_nettype wire

// ===== sv/dchs_sqrt_cell.sv =====
// one root bit of the square root chain
`default_nettype none
module dchs_sqrt_cell #(
  parameter int NB  = 38,
  parameter int SBW = 41
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [2*NB-1:0] rad_i,
  input  wire logic [NB+1:0]   rem_i,
  input  wire logic [NB-1:0]   root_i,
  input  wire logic [SBW-1:0]  side_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [2*NB-1:0]      rad_o,
  output logic [NB+1:0]        rem_o,
  output logic [NB-1:0]        root_o,
  output logic [SBW-1:0]       side_o
);
  logic            v_q;
  logic [NB+3:0]   cat, trial, diff;
  logic            ge;
  logic [2*NB-1:0] rad_q;
  logic [NB+1:0]   rem_q;
  logic [NB-1:0]   root_q;
  logic [SBW-1:0]  side_q;

  assign in_ready_o = !v_q || out_ready_i;
  assign cat   = {rem_i, rad_i[2*NB-1 -: 2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign ge    = (cat >= trial);
  assign diff  = cat - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rem_q  <= ge ? diff[NB+1:0] : cat[NB+1:0];
      root_q <= {root_i[NB-2:0], ge};
      rad_q  <= {rad_i[2*NB-3:0], 2'b00};
      side_q <= side_i;
    end
  end

  assign out_valid_o = v_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule
`default_nettype wire

// ===== sv/delta_carriage_height_solver_core.sv =====
// top level: config registers, front stages, square root cell chain, output stage
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+----
//  input   | in_valid_i, in_stall_o, nozzle_x/y/z_i    | in
//  result  | out_valid_o, out_stall_i, carriage_height_o, status_o | out
//  config  | cfg_we_i, cfg_index_i, cfg_data_i         | in
//
// one beat per cycle sustained while the output is not stalled; the path is 5 front stages, one cell per root
// bit (COORD_WIDTH+5 cells at the defaults), and the output register.
// stages advance independently, so bubbles collapse and a held result does
// not block input until the whole chain is full.
// reset is asynchronous, clears valid bits and loads register reset values.
`default_nettype none
module delta_carriage_height_solver_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] nozzle_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] nozzle_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] nozzle_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0]      carriage_height_o,
  output logic [1:0]                         status_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [2:0]                    cfg_index_i,
  input  wire logic [dchs_pkg::max2(dchs_pkg::ArmWidth, COORD_WIDTH)-1:0] cfg_data_i
);
  import dchs_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int BW  = bw_of(CW);
  localparam int NB  = nb_of(CW, FRAC_BITS);
  localparam int SBW = BW + 3;
  localparam int HW  = max2(BW, NB) + 2;
  localparam logic signed [HW-1:0] HMax = HW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [HW-1:0] HMin = -HMax - HW'(1);

  logic [ArmWidth-1:0]         arm_q;
  logic signed [CW-1:0]        base_x_q, base_y_q;
  logic signed [LeanWidth-1:0] lean_x_q, lean_y_q, lean_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_q    <= ArmReset;
      base_x_q <= '0;
      base_y_q <= '0;
      lean_x_q <= '0;
      lean_y_q <= '0;
      lean_z_q <= LeanOne;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegArm:   arm_q    <= cfg_data_i[ArmWidth-1:0];
        RegBaseX: base_x_q <= cfg_data_i[CW-1:0];
        RegBaseY: base_y_q <= cfg_data_i[CW-1:0];
        RegLeanX: lean_x_q <= cfg_data_i[LeanWidth-1:0];
        RegLeanY: lean_y_q <= cfg_data_i[LeanWidth-1:0];
        RegLeanZ: lean_z_q <= cfg_data_i[LeanWidth-1:0];
        default: ;
      endcase
    end
  end

  logic                 in_ready;
  logic                 f_valid;
  logic [2*NB-1:0]      f_rad;
  logic signed [BW-1:0] f_off;
  logic                 f_lf;
  logic [1:0]           f_status;

  assign in_stall_o = !in_ready;

  logic            c_valid [NB+1];
  logic            c_ready [NB+1];
  logic [2*NB-1:0] c_rad   [NB+1];
  logic [NB+1:0]   c_rem   [NB+1];
  logic [NB-1:0]   c_root  [NB+1];
  logic [SBW-1:0]  c_side  [NB+1];

  dchs_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .nozzle_x_i  (nozzle_x_i),
    .nozzle_y_i  (nozzle_y_i),
    .nozzle_z_i  (nozzle_z_i),
    .arm_i       (arm_q),
    .base_x_i    (base_x_q),
    .base_y_i    (base_y_q),
    .lean_x_i    (lean_x_q),
    .lean_y_i    (lean_y_q),
    .lean_z_i    (lean_z_q),
    .out_valid_o (f_valid),
    .out_ready_i (c_ready[0]),
    .rad_o       (f_rad),
    .off_o       (f_off),
    .lean_free_o (f_lf),
    .status_o    (f_status)
  );

  assign c_valid[0] = f_valid;
  assign c_rad[0]   = f_rad;
  assign c_rem[0]   = '0;
  assign c_root[0]  = '0;
  assign c_side[0]  = {f_status, f_lf, f_off};

  for (genvar i = 0; i < NB; i++) begin : g_cell
    dchs_sqrt_cell #(
      .NB (NB),
      .SBW(SBW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (c_valid[i]),
      .in_ready_o (c_ready[i]),
      .rad_i      (c_rad[i]),
      .rem_i      (c_rem[i]),
      .root_i     (c_root[i]),
      .side_i     (c_side[i]),
      .out_valid_o(c_valid[i+1]),
      .out_ready_i(c_ready[i+1]),
      .rad_o      (c_rad[i+1]),
      .rem_o      (c_rem[i+1]),
      .root_o     (c_root[i+1]),
      .side_o     (c_side[i+1])
    );
  end

  // root selection and saturation into the output register
  logic                 out_v_q;
  logic signed [HW-1:0] s_ext, off_ext, h1, h2, hsel;
  logic [1:0]           st_in, st_d;
  logic                 lf_in;
  logic signed [CW-1:0] h_d;
  logic signed [CW-1:0] h_q;
  logic [1:0]           st_q;

  assign c_ready[NB] = !out_v_q || !out_stall_i;
  assign st_in   = c_side[NB][SBW-1 -: 2];
  assign lf_in   = c_side[NB][BW];
  assign off_ext = HW'($signed(c_side[NB][BW-1:0]));
  assign s_ext   = $signed(HW'(c_root[NB]));
  assign h1      = off_ext + s_ext;
  assign h2      = off_ext - s_ext;

  always_comb begin
    st_d = st_in;
    hsel = h1;
    if (st_in == StOk && !lf_in) begin
      if (!h1[HW-1]) hsel = h1;
      else if (!h2[HW-1]) hsel = h2;
      else st_d = StBothNeg;
    end
    priority if (st_d != StOk) h_d = '0;
    else if (hsel > HMax) h_d = HMax[CW-1:0];
    else if (hsel < HMin) h_d = HMin[CW-1:0];
    else h_d = hsel[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (c_ready[NB]) begin
      out_v_q <= c_valid[NB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready[NB] && c_valid[NB]) begin
      h_q  <= h_d;
      st_q <= st_d;
    end
  end

  assign out_valid_o       = out_v_q;
  assign carriage_height_o = h_q;
  assign status_o          = st_q;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the delta carriage height solver core
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import dchs_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int DataW = 47;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] noz_x = '0, noz_y = '0, noz_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] height;
  logic [1:0] status;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = RegArm;
  logic [DataW-1:0] cfg_data = '0;

  typedef struct packed {
    logic signed [CW-1:0] height;
    status_e status;
  } solution_t;

  solution_t solutions_q[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit stall_rand = 1'b1;

  // local copy of the tower registers
  logic [46:0] arm_sq;
  logic signed [CW-1:0] base_x, base_y;
  logic signed [31:0] lean_x, lean_y, lean_z;

  delta_carriage_height_solver_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .nozzle_x_i(noz_x), .nozzle_y_i(noz_y), .nozzle_z_i(noz_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .carriage_height_o(height), .status_o(status),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL delta_carriage_height_solver_core");
      $finish;
    end
  end

  function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] clamp(input logic signed [127:0] h);
    if (h > 128'sd2147483647) return 32'sh7fffffff;
    if (h < -128'sd2147483648) return 32'sh80000000;
    return h[CW-1:0];
  endfunction

  function automatic solution_t solve_height(input logic signed [CW-1:0] x,
      input logic signed [CW-1:0] y, input logic signed [CW-1:0] z);
    solution_t s;
    logic signed [127:0] dx, dy, zz, arm, planar, lin, b, c, disc, rt;
    s.height = '0;
    dx = 128'(x) - 128'(base_x);
    dy = 128'(y) - 128'(base_y);
    zz = 128'(z);
    if (arm_sq == '0) begin
      s.status = StBadArm;
      return s;
    end
    arm = $signed({81'd0, arm_sq}) <<< FB;
    planar = dx * dx + dy * dy;
    if (lean_x == 0 && lean_y == 0 && lean_z == LeanOne) begin
      disc = arm - planar;
      if (disc < 0) begin
        s.status = StNoReach;
        return s;
      end
      s.height = clamp($signed({64'd0, floor_sqrt(disc)}) + zz);
      s.status = StOk;
      return s;
    end
    lin = dx * 128'(lean_x) + dy * 128'(lean_y) + zz * 128'(lean_z);
    b = (lin + (128'sd1 <<< 29)) >>> 30;
    c = planar + zz * zz - arm;
    disc = b * b - c;
    if (disc < 0) begin
      s.status = StNoReach;
      return s;
    end
    rt = $signed({64'd0, floor_sqrt(disc)});
    s.status = StOk;
    if (b + rt >= 0) s.height = clamp(b + rt);
    else if (b - rt >= 0) s.height = clamp(b - rt);
    else s.status = StBothNeg;
    return s;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [DataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      RegArm: arm_sq = val[46:0];
      RegBaseX: base_x = val[CW-1:0];
      RegBaseY: base_y = val[CW-1:0];
      RegLeanX: lean_x = val[31:0];
      RegLeanY: lean_y = val[31:0];
      RegLeanZ: lean_z = val[31:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_nozzle(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
      input logic signed [CW-1:0] z);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    // a gap drops valid, otherwise the next beat follows at once
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    noz_x <= x;
    noz_y <= y;
    noz_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    solutions_q.push_back(solve_height(x, y, z));
  endtask

  // result check, sampled at the edge the beat is taken
  always @(posedge clk) begin
    solution_t exp_s;
    if (rst_n && out_valid && !out_stall) begin
      if (solutions_q.size() == 0) begin
        $display("%0t: unexpected result height %0d status %0d", $time, height, status);
        errors++;
      end else begin
        exp_s = solutions_q.pop_front();
        if (height !== exp_s.height) begin
          $display("%0t: height expected %0d actual %0d", $time, exp_s.height, height);
          errors++;
        end
        if (status !== exp_s.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_s.status, status);
          errors++;
        end
      end
    end
  end

  // receiver stall, random, off, or held on for a long stretch
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (!stall_rand) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) < 3);
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (solutions_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] any_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  task automatic test_directed();
    logic signed [CW-1:0] ext[4];
    ext = '{32'sh80000000, 32'sh7fffffff, 32'sd0, -32'sd1};
    for (int i = 0; i < 4; i++) send_nozzle(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
    send_nozzle(0, 0, 0);
    send_nozzle(250 << 16, 0, 10 << 16);
    send_nozzle(251 << 16, 0, 0);
    send_nozzle(0, 0, 32'sh7fff0000);
    drain();
    write_reg(RegArm, 0);
    send_nozzle(1, 2, 3);
    drain();
    write_reg(RegArm, 47'h7fffffffffff);
    write_reg(RegBaseX, 32'h80000000);
    write_reg(RegBaseY, 32'h7fffffff);
    send_nozzle(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_nozzle(0, 0, 0);
    drain();
    // lean: both roots negative, unreachable and ok
    write_reg(RegArm, 47'd4096000000);
    write_reg(RegBaseX, 0);
    write_reg(RegBaseY, 0);
    write_reg(RegLeanX, 32'h40000000);
    write_reg(RegLeanY, 32'hc0000000);
    write_reg(RegLeanZ, 32'h00000000);
    send_nozzle(-(300 << 16), 0, 0);
    send_nozzle(0, 0, 300 << 16);
    send_nozzle(10 << 16, 0, 0);
    send_nozzle(32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    drain();
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < 10; phase++) begin
      write_reg(RegArm, ($urandom_range(0, 7) == 0) ? 47'({$urandom, $urandom})
                : 47'($urandom_range(50, 400) * $urandom_range(50, 400)) << FB);
      write_reg(RegBaseX, ($urandom_range(0, 1)) ? $urandom : 32'($urandom_range(0, 200 << 16)));
      write_reg(RegBaseY, ($urandom_range(0, 1)) ? $urandom : 32'($urandom_range(0, 200 << 16)));
      if (phase % 3 == 0) begin
        write_reg(RegLeanX, 0);
        write_reg(RegLeanY, 0);
        write_reg(RegLeanZ, 32'(LeanOne));
      end else begin
        write_reg(RegLeanX, 32'($signed($urandom_range(0, 1 << 31)) - (1 << 30)));
        write_reg(RegLeanY, 32'($signed($urandom_range(0, 1 << 31)) - (1 << 30)));
        write_reg(RegLeanZ, (phase == 4) ? 32'hc0000000 : 32'($urandom_range(0, 1 << 30)));
      end
      stall_rand = (phase != 5);
      for (int i = 0; i < 50; i++) send_nozzle(any_coord(), any_coord(), any_coord());
      drain();
    end
    stall_rand = 1'b1;
  endtask

  task automatic test_backpressure();
    int pushed;
    write_reg(RegLeanX, 0);
    write_reg(RegLeanY, 0);
    write_reg(RegLeanZ, 32'(LeanOne));
    hold_off = 1'b1;
    fork
      begin
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (pushed = 0; pushed < 60; pushed++)
          send_nozzle(any_coord(), any_coord(), any_coord());
        drain();
      end
    join
  endtask

  initial begin
    arm_sq = ArmReset;
    base_x = '0;
    base_y = '0;
    lean_x = '0;
    lean_y = '0;
    lean_z = LeanOne;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_configs();
    test_backpressure();
    if (errors == 0) $display("PASS delta_carriage_height_solver_core");
    else $display("FAIL delta_carriage_height_solver_core");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/dchs_pkg.sv
sv/dchs_front.sv
sv/dchs_sqrt_cell.sv
sv/delta_carriage_height_solver_core.sv
test/testbench.sv
